// ===== design/ppst_pkg.sv =====
// Shared types, constants and tables for the pure pursuit steering core.
`default_nettype none
package ppst_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_POSE   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam logic [2:0] STAT_TRACK  = 3'd0;
  localparam logic [2:0] STAT_IDLE   = 3'd1;
  localparam logic [2:0] STAT_GOAL   = 3'd2;
  localparam logic [2:0] STAT_STORED = 3'd3;
  localparam logic [2:0] STAT_FULL   = 3'd4;

  localparam logic [2:0] REG_WHEEL_BASE = 3'd0;
  localparam logic [2:0] REG_GAIN       = 3'd1;
  localparam logic [2:0] REG_MIN_LOOK   = 3'd2;
  localparam logic [2:0] REG_MAX_LOOK   = 3'd3;
  localparam logic [2:0] REG_CRUISE     = 3'd4;
  localparam logic [2:0] REG_GOAL_RAD   = 3'd5;

  localparam logic signed [21:0] ANG_PI      = 22'sd205887;
  localparam logic signed [21:0] ANG_HALF_PI = 22'sd102944;
  localparam logic signed [21:0] ANG_TWO_PI  = 22'sd411775;
  localparam logic signed [19:0] GAIN_INV    = 20'sd39797;

  localparam int NUM_W = 50;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [30:0]      den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_LOOK = 15'h0002,
    S_LIM  = 15'h0004,
    S_SQL  = 15'h0008,
    S_SQG  = 15'h0010,
    S_RD   = 15'h0020,
    S_DX   = 15'h0040,
    S_MX   = 15'h0080,
    S_MY   = 15'h0100,
    S_CHK  = 15'h0200,
    S_ATAN = 15'h0400,
    S_FOLD = 15'h0800,
    S_SIN  = 15'h1000,
    S_MUL  = 15'h2000,
    S_DIV  = 15'h4000
  } state_t;

  function automatic logic [16:0] atan_tab(input logic [3:0] i);
    logic [16:0] v;
    case (i)
      4'd0:    v = 17'd51472;
      4'd1:    v = 17'd30386;
      4'd2:    v = 17'd16055;
      4'd3:    v = 17'd8150;
      4'd4:    v = 17'd4091;
      4'd5:    v = 17'd2047;
      4'd6:    v = 17'd1024;
      4'd7:    v = 17'd512;
      4'd8:    v = 17'd256;
      4'd9:    v = 17'd128;
      4'd10:   v = 17'd64;
      4'd11:   v = 17'd32;
      4'd12:   v = 17'd16;
      4'd13:   v = 17'd8;
      4'd14:   v = 17'd4;
      default: v = 17'd2;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/pure_pursuit_steering_core.sv =====
// Pure pursuit steering core: path store, target search, CORDIC and divide.
// Clear, append, unknown and idle pose requests go via S_DIV to the output register;
// other poses run LOOK, LIM, SQL, SQG, then RD, DX, MX, MY, CHK per point, the final
// point twice if none is far enough; a goal ends there, tracking adds ATAN, FOLD, SIN, MUL
// and a divide if needed. One at a time; a new one is taken while the last result waits.
// rst_n is synchronous, active low; path store contents are not cleared.
`default_nettype none
module pure_pursuit_steering_core #(
  parameter int PATH_DEPTH = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // point_x, point_y, pose_x, pose_y, pose_yaw, speed
  input  wire logic [175:0] in_tdata,
  // action
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // linear_cmd, angular_cmd, target_index
  output logic [71:0]       out_tdata,
  // status
  output logic [2:0]        out_tuser,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata
);
  localparam int LW = $clog2(PATH_DEPTH + 1);
  localparam int IW = $clog2(PATH_DEPTH);
  localparam int TW = (LW > 8) ? LW : 8;
  localparam int NW = ppst_pkg::NUM_W;

  ppst_pkg::state_t st_r, st_nxt;

  logic [30:0] wb_r, gain_r, minl_r, maxl_r, grad_r;
  logic signed [31:0] cruise_r;

  logic signed [31:0] px_r, py_r, spd_r;
  logic signed [15:0] yaw_r;

  logic [LW-1:0] len_r, len_nxt;
  logic [IW-1:0] last_r, last_nxt;
  logic          goal_r, goal_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic          final_r, final_nxt;
  logic          div_wait_r;

  logic [63:0] mem [PATH_DEPTH];
  logic [63:0] rd_q;
  logic        wr_en;

  logic [62:0] prod_r;
  logic [30:0] look_r;
  logic [61:0] lsq_r, gsq_r, sqx_r, sqy_r;
  logic signed [32:0] dx_r, dy_r;
  logic [30:0] ax_r, ay_r;
  logic        big_r, zero_r;

  logic signed [35:0] cx_r, cy_r;
  logic signed [21:0] cz_r;
  logic signed [19:0] sx_r, sy_r;
  logic signed [21:0] sa_r;
  logic [3:0]  it_r;
  logic signed [NW:0] num_r;

  logic signed [31:0] res_lin_r;
  logic signed [31:0] res_ang_r;
  logic [LW-1:0] res_idx_r;
  logic [2:0]    res_st_r;

  logic        out_valid_r;
  logic [71:0] out_data_r;
  logic [2:0]  out_user_r;

  ppst_pkg::div_req_t dreq;
  ppst_pkg::div_rsp_t drsp;

  logic accept;
  assign in_tready = (st_r == ppst_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;

  ppst_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r     <= 31'd131072;
      gain_r   <= 31'd19661;
      minl_r   <= 31'd131072;
      maxl_r   <= 31'd655360;
      cruise_r <= 32'sd65536;
      grad_r   <= 31'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        ppst_pkg::REG_WHEEL_BASE: wb_r     <= cfg_wdata[30:0];
        ppst_pkg::REG_GAIN:       gain_r   <= cfg_wdata[30:0];
        ppst_pkg::REG_MIN_LOOK:   minl_r   <= cfg_wdata[30:0];
        ppst_pkg::REG_MAX_LOOK:   maxl_r   <= cfg_wdata[30:0];
        ppst_pkg::REG_CRUISE:     cruise_r <= cfg_wdata;
        ppst_pkg::REG_GOAL_RAD:   grad_r   <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // path store
  assign wr_en = accept && (in_tuser == ppst_pkg::ACT_APPEND) && (len_r < LW'(PATH_DEPTH));
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[len_r[IW-1:0]] <= {in_tdata[31:0], in_tdata[63:32]};
    end
    rd_q <= mem[idx_r[IW-1:0]];
  end

  function automatic logic signed [21:0] atan_tab_s(input logic [3:0] i);
    logic [16:0] v;
    v = ppst_pkg::atan_tab(i);
    return $signed({5'd0, v});
  endfunction

  // datapath combinational pieces
  logic [31:0]   spd_abs;
  logic [47:0]   look_raw, look_c1;
  logic signed [32:0] dx_c, dy_c;
  logic [32:0]   ax_c, ay_c;
  logic [62:0]   dsq;
  logic          found, near;
  logic [LW-1:0] last_ext, len_m1;
  logic signed [21:0] alpha, alpha_w, afold;
  logic signed [17:0] sinc;
  logic signed [NW:0] num_c;
  logic [NW-1:0] num_mag;
  logic          num_neg;
  logic signed [31:0] ang_sat;
  logic signed [21:0] tabv;
  logic signed [35:0] cx0, cy0;

  always_comb begin
    spd_abs  = spd_r[31] ? 32'(-spd_r) : 32'(spd_r);
    look_raw = {1'b0, prod_r[62:16]} + {17'd0, minl_r};
    look_c1  = (look_raw > {17'd0, maxl_r}) ? {17'd0, maxl_r} : look_raw;
    if (look_c1 < {17'd0, minl_r}) look_c1 = {17'd0, minl_r};
    dx_c = $signed({rd_q[63], rd_q[63:32]}) - $signed({px_r[31], px_r});
    dy_c = $signed({rd_q[31], rd_q[31:0]}) - $signed({py_r[31], py_r});
    ax_c = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
    ay_c = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
    dsq   = {1'b0, sqx_r} + {1'b0, sqy_r};
    found = big_r || (dsq >= {1'b0, lsq_r});
    near  = !(big_r || (dsq >= {1'b0, gsq_r}));
    last_ext = LW'(last_r);
    len_m1   = len_r - 1'b1;
    tabv  = 22'(atan_tab_s(it_r));
    alpha = cz_r - ($signed({{6{yaw_r[15]}}, yaw_r}) <<< 3);
    alpha_w = alpha;
    if (alpha > ppst_pkg::ANG_PI) alpha_w = alpha - ppst_pkg::ANG_TWO_PI;
    else if (alpha < -ppst_pkg::ANG_PI) alpha_w = alpha + ppst_pkg::ANG_TWO_PI;
    afold = alpha_w;
    if (alpha_w > ppst_pkg::ANG_HALF_PI) afold = ppst_pkg::ANG_PI - alpha_w;
    else if (alpha_w < -ppst_pkg::ANG_HALF_PI) afold = -ppst_pkg::ANG_PI - alpha_w;
    if (sy_r > 20'sd65536) sinc = 18'sd65536;
    else if (sy_r < -20'sd65536) sinc = -18'sd65536;
    else sinc = sy_r[17:0];
    num_c   = (NW + 1)'(spd_r * sinc) <<< 1;
    num_mag = num_c[NW] ? NW'(-num_c) : NW'(num_c);
    num_neg = num_r[NW];
    if (num_neg) begin
      if (drsp.quo > NW'(64'h80000000)) ang_sat = 32'sh80000000;
      else ang_sat = 32'(-drsp.quo);
    end else begin
      if (drsp.quo > NW'(64'h7fffffff)) ang_sat = 32'sh7fffffff;
      else ang_sat = 32'(drsp.quo);
    end
    cx0 = 36'(dx_r);
    cy0 = 36'(dy_r);
  end

  // control
  always_comb begin
    st_nxt    = st_r;
    len_nxt   = len_r;
    last_nxt  = last_r;
    goal_nxt  = goal_r;
    idx_nxt   = idx_r;
    final_nxt = final_r;
    dreq.start = 1'b0;
    dreq.num   = num_mag;
    dreq.den   = look_r;
    case (st_r)
      ppst_pkg::S_IDLE: begin
        if (accept) begin
          st_nxt = ppst_pkg::S_DIV;
          case (in_tuser)
            ppst_pkg::ACT_CLEAR: begin
              len_nxt  = '0;
              last_nxt = '0;
              goal_nxt = 1'b0;
            end
            ppst_pkg::ACT_APPEND: begin
              if (wr_en) len_nxt = len_r + 1'b1;
            end
            ppst_pkg::ACT_POSE: begin
              if (len_r != '0 && !goal_r) st_nxt = ppst_pkg::S_LOOK;
            end
            default: ;
          endcase
        end
      end
      ppst_pkg::S_LOOK: st_nxt = ppst_pkg::S_LIM;
      ppst_pkg::S_LIM:  st_nxt = ppst_pkg::S_SQL;
      ppst_pkg::S_SQL:  st_nxt = ppst_pkg::S_SQG;
      ppst_pkg::S_SQG: begin
        st_nxt = ppst_pkg::S_RD;
        if (last_ext >= len_r) begin
          idx_nxt   = len_m1;
          final_nxt = 1'b1;
        end else begin
          idx_nxt   = last_ext;
          final_nxt = 1'b0;
        end
      end
      ppst_pkg::S_RD: st_nxt = ppst_pkg::S_DX;
      ppst_pkg::S_DX: st_nxt = ppst_pkg::S_MX;
      ppst_pkg::S_MX: st_nxt = ppst_pkg::S_MY;
      ppst_pkg::S_MY: st_nxt = ppst_pkg::S_CHK;
      ppst_pkg::S_CHK: begin
        if (final_r || found) begin
          last_nxt = idx_r[IW-1:0];
          if (idx_r == len_m1 && near) begin
            goal_nxt = 1'b1;
            st_nxt   = ppst_pkg::S_DIV;
          end else begin
            st_nxt = ppst_pkg::S_ATAN;
          end
        end else begin
          st_nxt = ppst_pkg::S_RD;
          if (idx_r + 1'b1 >= len_r) begin
            idx_nxt   = len_m1;
            final_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ppst_pkg::S_ATAN: if (it_r == 4'd15) st_nxt = ppst_pkg::S_FOLD;
      ppst_pkg::S_FOLD: st_nxt = ppst_pkg::S_SIN;
      ppst_pkg::S_SIN:  if (it_r == 4'd15) st_nxt = ppst_pkg::S_MUL;
      ppst_pkg::S_MUL: begin
        st_nxt = ppst_pkg::S_DIV;
        if (!(wb_r == '0 || num_c == '0 || look_r == '0)) dreq.start = 1'b1;
      end
      ppst_pkg::S_DIV: begin
        if (!div_wait_r && (!out_valid_r || out_tready)) st_nxt = ppst_pkg::S_IDLE;
      end
      default: st_nxt = ppst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ppst_pkg::S_IDLE;
      len_r      <= '0;
      last_r     <= '0;
      goal_r     <= 1'b0;
      final_r    <= 1'b0;
      div_wait_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      len_r   <= len_nxt;
      last_r  <= last_nxt;
      goal_r  <= goal_nxt;
      final_r <= final_nxt;
      if (dreq.start) div_wait_r <= 1'b1;
      else if (drsp.done) div_wait_r <= 1'b0;
    end
    idx_r <= idx_nxt;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      ppst_pkg::S_IDLE: begin
        if (accept) begin
          px_r  <= in_tdata[95:64];
          py_r  <= in_tdata[127:96];
          yaw_r <= in_tdata[143:128];
          spd_r <= in_tdata[175:144];
          res_lin_r <= '0;
          res_ang_r <= '0;
          res_st_r  <= ppst_pkg::STAT_IDLE;
          res_idx_r <= '0;
          case (in_tuser)
            ppst_pkg::ACT_APPEND: begin
              res_idx_r <= len_r;
              res_st_r  <= wr_en ? ppst_pkg::STAT_STORED : ppst_pkg::STAT_FULL;
            end
            ppst_pkg::ACT_POSE: begin
              res_idx_r <= LW'(last_r);
              if (len_r != '0 && !goal_r) res_st_r <= ppst_pkg::STAT_TRACK;
            end
            default: ;
          endcase
        end
      end
      ppst_pkg::S_LOOK: prod_r <= {32'd0, gain_r} * {31'd0, spd_abs};
      ppst_pkg::S_LIM:  look_r <= look_c1[30:0];
      ppst_pkg::S_SQL:  lsq_r  <= {31'd0, look_r} * {31'd0, look_r};
      ppst_pkg::S_SQG:  gsq_r  <= {31'd0, grad_r} * {31'd0, grad_r};
      ppst_pkg::S_DX: begin
        dx_r   <= dx_c;
        dy_r   <= dy_c;
        big_r  <= (ax_c > 33'h7fffffff) || (ay_c > 33'h7fffffff);
        ax_r   <= ax_c[30:0];
        ay_r   <= ay_c[30:0];
        zero_r <= (dx_c == '0) && (dy_c == '0);
      end
      ppst_pkg::S_MX: sqx_r <= {31'd0, ax_r} * {31'd0, ay_r ^ ay_r ^ ax_r};
      ppst_pkg::S_MY: sqy_r <= {31'd0, ay_r} * {31'd0, ay_r};
      ppst_pkg::S_CHK: begin
        res_idx_r <= idx_r;
        it_r      <= '0;
        if (final_r || found) begin
          if (idx_r == len_m1 && near) res_st_r <= ppst_pkg::STAT_GOAL;
          cz_r <= '0;
          cx_r <= cx0;
          cy_r <= cy0;
          if (dx_r < 0) begin
            if (dy_r >= 0) begin
              cx_r <= cy0;
              cy_r <= -cx0;
              cz_r <= ppst_pkg::ANG_HALF_PI;
            end else begin
              cx_r <= -cy0;
              cy_r <= cx0;
              cz_r <= -ppst_pkg::ANG_HALF_PI;
            end
          end
        end
      end
      ppst_pkg::S_ATAN: begin
        it_r <= it_r + 1'b1;
        if (!zero_r) begin
          if (!cy_r[35]) begin
            cx_r <= cx_r + (cy_r >>> it_r);
            cy_r <= cy_r - (cx_r >>> it_r);
            cz_r <= cz_r + tabv;
          end else begin
            cx_r <= cx_r - (cy_r >>> it_r);
            cy_r <= cy_r + (cx_r >>> it_r);
            cz_r <= cz_r - tabv;
          end
        end
      end
      ppst_pkg::S_FOLD: begin
        sx_r <= ppst_pkg::GAIN_INV;
        sy_r <= '0;
        sa_r <= afold;
        it_r <= '0;
      end
      ppst_pkg::S_SIN: begin
        it_r <= it_r + 1'b1;
        if (!sa_r[21]) begin
          sx_r <= sx_r - (sy_r >>> it_r);
          sy_r <= sy_r + (sx_r >>> it_r);
          sa_r <= sa_r - tabv;
        end else begin
          sx_r <= sx_r + (sy_r >>> it_r);
          sy_r <= sy_r - (sx_r >>> it_r);
          sa_r <= sa_r + tabv;
        end
      end
      ppst_pkg::S_MUL: begin
        num_r <= num_c;
        res_lin_r <= cruise_r;
        if (wb_r != '0 && num_c != '0 && look_r == '0)
          res_ang_r <= num_c[NW] ? 32'sh80000000 : 32'sh7fffffff;
      end
      ppst_pkg::S_DIV: begin
        if (drsp.done) res_ang_r <= ang_sat;
      end
      default: ;
    endcase
  end

  // output register
  logic load;
  logic [TW-1:0] tidx;
  assign load = (st_r == ppst_pkg::S_DIV) && (st_nxt == ppst_pkg::S_IDLE);
  assign tidx = TW'(res_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (load) begin
      out_data_r <= {tidx[7:0], res_ang_r, res_lin_r};
      out_user_r <= res_st_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
endmodule
`default_nettype wire

// ===== design/ppst_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module ppst_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ppst_pkg::div_req_t req,
  output ppst_pkg::div_rsp_t      rsp
);
  localparam int NW = ppst_pkg::NUM_W;
  localparam int CW = $clog2(NW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [30:0]   rem_r, rem_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [31:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    trial    = {rem_r, q_r[NW-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = req.num;
    end else if (busy_r) begin
      if (trial >= {1'b0, req.den}) begin
        rem_nxt = 31'(trial - {1'b0, req.den});
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[30:0];
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
endmodule
`default_nettype wire

// ===== design/ppst_check.sv =====
// Port-level checks for the pure pursuit steering core, bound to the top level.
`default_nettype none
module ppst_check (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [175:0] in_tdata,
  input wire logic [1:0]   in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [71:0]  out_tdata,
  input wire logic [2:0]   out_tuser,
  input wire logic         cfg_we,
  input wire logic [2:0]   cfg_index,
  input wire logic [31:0]  cfg_wdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_lin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ppst_pkg::STAT_TRACK |-> out_tdata[31:0] == 32'd0)
    else $error("linear command set while not tracking");

  a_ang_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ppst_pkg::STAT_TRACK |-> out_tdata[63:32] == 32'd0)
    else $error("angular command set while not tracking");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
endmodule

bind pure_pursuit_steering_core ppst_check u_ppst_check (.*);
`default_nettype wire
